@@ hdl/gap_buffer_list_assert.svh @@
// Assertion macros for the gap buffer list top level.
`ifndef GAP_BUFFER_LIST_ASSERT_SVH
`define GAP_BUFFER_LIST_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GBL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gap_buffer_list: check failed");

// Next-cycle implication, checked outside reset.
`define GBL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gap_buffer_list: check failed");

`endif

@@ hdl/gbl_pkg.sv @@
// Package: sizes, codes and control structs of the gap buffer list.
package gbl_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    localparam int FUNC_W = 2;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 7;
    localparam int STAT_W = 2;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((POS_W > CW) ? POS_W : CW) + 1;

    localparam int GSW  = (AW < 3) ? AW : 3;
    localparam int GRP  = 1 << GSW;
    localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

    localparam logic [FUNC_W-1:0] FN_READ   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                  shift_en;
        logic                  shift_left;
        logic [XW-1:0]         lo;
        logic [XW-1:0]         hi;
        logic                  wr_en;
        logic [XW-1:0]         wr_addr;
        logic [DATA_WIDTH-1:0] wr_data;
    } t_cell_ctl;

    typedef struct packed {
        t_cell_ctl     slot;
        logic          rd_grp;
        logic          rd_sel;
        logic [AW-1:0] rd_addr;
    } t_row_ctl;

endpackage

@@ hdl/gbl_ifs.sv @@
// Handshake interfaces for the request and response words.
interface gbl_req_if;
    logic                       valid;
    logic                       ready;
    logic [gbl_pkg::FUNC_W-1:0] func;
    logic [gbl_pkg::POS_W-1:0]  position;
    logic [gbl_pkg::VAL_W-1:0]  value;

    modport source (output valid, func, position, value, input ready);
    modport sink   (input valid, func, position, value, output ready);
endinterface

interface gbl_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [gbl_pkg::VAL_W-1:0]  read_data;
    logic [gbl_pkg::CNT_W-1:0]  element_count;
    logic [gbl_pkg::STAT_W-1:0] status;

    modport source (output valid, read_data, element_count, status, input ready);
    modport sink   (input valid, read_data, element_count, status, output ready);
endinterface

@@ hdl/gbl_cell.sv @@
// One storage cell of the row: holds a slot, shifts from a neighbor or takes a write.
module gbl_cell (
    input  logic                           i_clk,
    input  logic [gbl_pkg::XW-1:0]         i_idx,
    input  gbl_pkg::t_cell_ctl             i_ctl,
    input  logic [gbl_pkg::DATA_WIDTH-1:0] i_left,
    input  logic [gbl_pkg::DATA_WIDTH-1:0] i_right,
    output logic [gbl_pkg::DATA_WIDTH-1:0] o_data
);

    logic [gbl_pkg::DATA_WIDTH-1:0] r_data;
    logic [gbl_pkg::DATA_WIDTH-1:0] n_data;
    logic                           w_win_left;
    logic                           w_win_right;

    assign w_win_left  = (i_idx >= i_ctl.lo) && (i_idx < i_ctl.hi);
    assign w_win_right = (i_idx > i_ctl.lo) && (i_idx <= i_ctl.hi);

    always_comb begin
        n_data = r_data;
        if (i_ctl.shift_en) begin
            if (i_ctl.shift_left && w_win_left) begin
                n_data = i_right;
            end else if (!i_ctl.shift_left && w_win_right) begin
                n_data = i_left;
            end
        end
        if (i_ctl.wr_en && (i_idx == i_ctl.wr_addr)) begin
            n_data = i_ctl.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ hdl/gbl_row.sv @@
// Row of storage cells with a registered two-level read tree.
module gbl_row (
    input  logic                           i_clk,
    input  gbl_pkg::t_row_ctl              i_ctl,
    output logic [gbl_pkg::DATA_WIDTH-1:0] o_rd_data
);

    logic [gbl_pkg::DATA_WIDTH-1:0] w_data [gbl_pkg::CAPACITY];
    logic [gbl_pkg::DATA_WIDTH-1:0] r_grp  [gbl_pkg::NGRP];
    logic [gbl_pkg::DATA_WIDTH-1:0] n_grp  [gbl_pkg::NGRP];
    logic [gbl_pkg::AW-1:0]         r_gsel;
    logic [gbl_pkg::DATA_WIDTH-1:0] r_rd;
    logic [gbl_pkg::DATA_WIDTH-1:0] n_rd;
    logic [gbl_pkg::AW-1:0]         w_lo_sel;

    for (genvar j = 0; j < gbl_pkg::CAPACITY; j++) begin : g_cell
        logic [gbl_pkg::DATA_WIDTH-1:0] w_left;
        logic [gbl_pkg::DATA_WIDTH-1:0] w_right;

        if (j == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[j-1];
        end

        if (j == gbl_pkg::CAPACITY - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[j+1];
        end

        gbl_cell u_cell (
            .i_clk   (i_clk),
            .i_idx   (gbl_pkg::XW'(j)),
            .i_ctl   (i_ctl.slot),
            .i_left  (w_left),
            .i_right (w_right),
            .o_data  (w_data[j])
        );
    end

    assign w_lo_sel = i_ctl.rd_addr & gbl_pkg::AW'(gbl_pkg::GRP - 1);

    always_comb begin
        for (int g = 0; g < gbl_pkg::NGRP; g++) begin
            n_grp[g] = '0;
            for (int k = 0; k < gbl_pkg::GRP; k++) begin
                if (((g * gbl_pkg::GRP + k) < gbl_pkg::CAPACITY) &&
                    (gbl_pkg::AW'(k) == w_lo_sel)) begin
                    n_grp[g] = w_data[g * gbl_pkg::GRP + k];
                end
            end
        end
    end

    always_comb begin
        n_rd = '0;
        for (int g = 0; g < gbl_pkg::NGRP; g++) begin
            if (gbl_pkg::AW'(g) == r_gsel) begin
                n_rd = r_grp[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_grp) begin
            r_grp  <= n_grp;
            r_gsel <= i_ctl.rd_addr >> gbl_pkg::GSW;
        end
        if (i_ctl.rd_sel) begin
            r_rd <= n_rd;
        end
    end

    assign o_rd_data = r_rd;

endmodule

@@ hdl/gap_buffer_list.sv @@
// Top level: gap buffer indexed list controller over a shifting row of cells.
// Each request word reads, inserts or removes one element at a logical index
// and answers with one response word carrying the read data, the element count
// after the operation and a status. One request is in work at a time; a
// request first moves or opens the gap in S_MOVE, where the cells between
// the shift bounds move one slot per cycle while shift steps remain, then
// writes in S_WRITE or reads through the registered read tree in S_RD_GRP
// and S_RD_SEL if it needs to, and ends in S_DONE. A finished request also
// waits as long as the previous response word still sits in the output
// register. A new request is taken while the last response word still
// waits in the output register.
`include "gap_buffer_list_assert.svh"

module gap_buffer_list (
    input  logic i_clk,
    input  logic i_rst_n,
    gbl_req_if.sink   i_req,
    gbl_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOVE,
        S_WRITE,
        S_RD_GRP,
        S_RD_SEL,
        S_DONE
    } t_state;

    t_state r_state;

    logic [gbl_pkg::CW-1:0]         r_count;
    logic                           r_gv;
    logic [gbl_pkg::AW-1:0]         r_gb;
    logic [gbl_pkg::CW-1:0]         r_gl;

    logic [gbl_pkg::CW-1:0]         r_steps;
    logic                           r_left;
    logic [gbl_pkg::XW-1:0]         r_lo;
    logic [gbl_pkg::XW-1:0]         r_hi;
    logic                           r_wr;
    logic [gbl_pkg::XW-1:0]         r_wr_addr;
    logic [gbl_pkg::DATA_WIDTH-1:0] r_wr_data;
    logic                           r_rd;
    logic [gbl_pkg::AW-1:0]         r_rd_addr;
    logic [gbl_pkg::STAT_W-1:0]     r_status;

    logic                           r_o_valid;
    logic [gbl_pkg::VAL_W-1:0]      r_o_rdata;
    logic [gbl_pkg::CNT_W-1:0]      r_o_count;
    logic [gbl_pkg::STAT_W-1:0]     r_o_status;

    logic [gbl_pkg::CW-1:0]         n_count;
    logic                           n_gv;
    logic [gbl_pkg::AW-1:0]         n_gb;
    logic [gbl_pkg::CW-1:0]         n_gl;
    logic [gbl_pkg::CW-1:0]         n_steps;
    logic                           n_left;
    logic [gbl_pkg::XW-1:0]         n_lo;
    logic [gbl_pkg::XW-1:0]         n_hi;
    logic                           n_wr;
    logic [gbl_pkg::XW-1:0]         n_wr_addr;
    logic                           n_rd;
    logic [gbl_pkg::STAT_W-1:0]     n_status;

    logic                           w_acc;
    logic [gbl_pkg::XW-1:0]         w_pos;
    logic [gbl_pkg::XW-1:0]         w_cnt;
    logic [gbl_pkg::XW-1:0]         w_gb;
    logic [gbl_pkg::XW-1:0]         w_gl;
    logic [gbl_pkg::XW-1:0]         w_cap;
    logic [gbl_pkg::XW-1:0]         w_phys;
    logic [gbl_pkg::XW-1:0]         w_occ;
    logic                           w_to_left;
    logic [gbl_pkg::CW-1:0]         w_to_steps;
    logic [gbl_pkg::XW-1:0]         w_to_lo;
    logic [gbl_pkg::XW-1:0]         w_to_hi;
    logic [gbl_pkg::CW-1:0]         w_gln;

    gbl_pkg::t_row_ctl              w_row_ctl;
    logic [gbl_pkg::DATA_WIDTH-1:0] w_row_rdata;

    assign w_acc = i_req.valid && i_req.ready;

    assign w_pos = gbl_pkg::XW'(i_req.position);
    assign w_cnt = gbl_pkg::XW'(r_count);
    assign w_gb  = gbl_pkg::XW'(r_gb);
    assign w_gl  = gbl_pkg::XW'(r_gl);
    assign w_cap = gbl_pkg::XW'(gbl_pkg::CAPACITY);
    assign w_occ = w_cnt + w_gl;

    assign w_phys = (r_gv && (w_pos >= w_gb)) ? (w_pos + w_gl) : w_pos;

    // move the gap to the requested index
    assign w_to_left  = w_gb < w_pos;
    assign w_to_steps = (w_gb != w_pos) ? r_gl : '0;
    assign w_to_lo    = w_to_left ? w_gb : w_pos;
    assign w_to_hi    = w_to_left ? (w_pos + w_gl - gbl_pkg::XW'(1))
                                  : (w_gb + w_gl - gbl_pkg::XW'(1));

    assign w_gln = gbl_pkg::CW'((w_cap - w_cnt) >> 1);

    always_comb begin
        n_count   = r_count;
        n_gv      = r_gv;
        n_gb      = r_gb;
        n_gl      = r_gl;
        n_steps   = '0;
        n_left    = w_to_left;
        n_lo      = w_to_lo;
        n_hi      = w_to_hi;
        n_wr      = 1'b0;
        n_wr_addr = w_pos;
        n_rd      = 1'b0;
        n_status  = gbl_pkg::ST_OK;
        case (i_req.func)
            gbl_pkg::FN_READ: begin
                if (w_pos >= w_cnt) begin
                    n_status = gbl_pkg::ST_RANGE;
                end else begin
                    n_rd = w_phys < w_cap;
                end
            end
            gbl_pkg::FN_INSERT: begin
                if (w_pos > w_cnt) begin
                    n_status = gbl_pkg::ST_RANGE;
                end else if (w_cnt >= w_cap) begin
                    n_status = gbl_pkg::ST_FULL;
                end else begin
                    n_count = r_count + gbl_pkg::CW'(1);
                    n_wr    = 1'b1;
                    if (w_pos == w_cnt) begin
                        if (w_phys >= w_cap) begin
                            n_steps = w_to_steps;
                            n_gv    = 1'b0;
                            n_gb    = gbl_pkg::AW'(w_pos);
                        end else begin
                            n_wr_addr = w_phys;
                        end
                    end else if (!r_gv) begin
                        n_left = 1'b0;
                        n_lo   = w_pos;
                        if ((w_cnt + gbl_pkg::XW'(2)) < w_cap) begin
                            n_gv    = 1'b1;
                            n_gb    = gbl_pkg::AW'(w_pos + gbl_pkg::XW'(1));
                            n_gl    = w_gln;
                            n_hi    = w_cnt + gbl_pkg::XW'(w_gln);
                            n_steps = w_gln + gbl_pkg::CW'(1);
                        end else begin
                            n_hi    = w_cnt;
                            n_steps = gbl_pkg::CW'(1);
                        end
                    end else begin
                        n_steps = w_to_steps;
                        n_gl    = r_gl - gbl_pkg::CW'(1);
                        if (r_gl == gbl_pkg::CW'(1)) begin
                            n_gv = 1'b0;
                            n_gb = gbl_pkg::AW'(w_pos);
                        end else begin
                            n_gb = gbl_pkg::AW'(w_pos + gbl_pkg::XW'(1));
                        end
                    end
                end
            end
            gbl_pkg::FN_REMOVE: begin
                if (w_pos >= w_cnt) begin
                    n_status = gbl_pkg::ST_RANGE;
                end else begin
                    n_count = r_count - gbl_pkg::CW'(1);
                    if (w_pos == (w_cnt - gbl_pkg::XW'(1))) begin
                        if (r_gv && (w_gb == w_pos)) begin
                            n_gv = 1'b0;
                        end
                    end else if (r_gv) begin
                        n_steps = w_to_steps;
                        n_gb    = gbl_pkg::AW'(w_pos);
                        n_gl    = r_gl + gbl_pkg::CW'(1);
                    end else begin
                        n_gv = 1'b1;
                        n_gb = gbl_pkg::AW'(w_pos);
                        n_gl = gbl_pkg::CW'(1);
                    end
                    if (r_count == gbl_pkg::CW'(1)) begin
                        n_gv = 1'b0;
                    end
                end
            end
            default: begin
                n_status = gbl_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_gv      <= 1'b0;
            r_gb      <= '0;
            r_gl      <= '0;
            r_steps   <= '0;
            r_wr      <= 1'b0;
            r_rd      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_count   <= n_count;
                        r_gv      <= n_gv;
                        r_gb      <= n_gb;
                        r_gl      <= n_gl;
                        r_steps   <= n_steps;
                        r_left    <= n_left;
                        r_lo      <= n_lo;
                        r_hi      <= n_hi;
                        r_wr      <= n_wr;
                        r_wr_addr <= n_wr_addr;
                        r_wr_data <= gbl_pkg::DATA_WIDTH'(i_req.value);
                        r_rd      <= n_rd;
                        r_rd_addr <= gbl_pkg::AW'(w_phys);
                        r_status  <= n_status;
                        r_state   <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    if (r_steps == '0) begin
                        if (r_wr) begin
                            r_state <= S_WRITE;
                        end else if (r_rd) begin
                            r_state <= S_RD_GRP;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_steps <= r_steps - gbl_pkg::CW'(1);
                    end
                end
                S_WRITE: begin
                    r_state <= S_DONE;
                end
                S_RD_GRP: begin
                    r_state <= S_RD_SEL;
                end
                S_RD_SEL: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_o_valid || o_rsp.ready) begin
                        r_o_valid  <= 1'b1;
                        r_o_rdata  <= r_rd ? gbl_pkg::VAL_W'(w_row_rdata) : '0;
                        r_o_count  <= gbl_pkg::CNT_W'(r_count);
                        r_o_status <= r_status;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        w_row_ctl.slot.shift_en   = (r_state == S_MOVE) && (r_steps != '0);
        w_row_ctl.slot.shift_left = r_left;
        w_row_ctl.slot.lo         = r_lo;
        w_row_ctl.slot.hi         = r_hi;
        w_row_ctl.slot.wr_en      = (r_state == S_WRITE);
        w_row_ctl.slot.wr_addr    = r_wr_addr;
        w_row_ctl.slot.wr_data    = r_wr_data;
        w_row_ctl.rd_grp          = (r_state == S_RD_GRP);
        w_row_ctl.rd_sel          = (r_state == S_RD_SEL);
        w_row_ctl.rd_addr         = r_rd_addr;
    end

    gbl_row u_row (
        .i_clk     (i_clk),
        .i_ctl     (w_row_ctl),
        .o_rd_data (w_row_rdata)
    );

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.read_data     = r_o_rdata;
    assign o_rsp.element_count = r_o_count;
    assign o_rsp.status        = r_o_status;

    `GBL_ASSERT_IMP(a_count_bound, 1'b1, w_cnt <= w_cap)
    `GBL_ASSERT_IMP(a_gap_nonempty, r_gv, r_gl != '0)
    `GBL_ASSERT_IMP(a_gap_fits, r_gv, w_occ <= w_cap)
    `GBL_ASSERT_NEXT(a_accept_moves, w_acc, r_state == S_MOVE)

endmodule
